/* rtl/sha256_stream_hasher_core_defines.svh */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared concurrent assertion forms used by the hasher core.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/shash_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types and constant tables for the hasher core and its units.
// ----------------------------------------------------------------------------
package shash_pkg;

   // Working variables a through h of the compression rounds.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
      logic [31:0] f;
      logic [31:0] g;
      logic [31:0] h;
   } work_type;

   // Control of the message schedule window.
   typedef struct packed {
      logic       load;
      logic       step;
      logic [7:0] data;
   } sched_ctrl_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LENGTH_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

/* rtl/shash_sched.sv */
// ----------------------------------------------------------------------------
// SHA-256 message schedule window
// Sixteen-word shift line that collects block bytes and expands the schedule.
// ----------------------------------------------------------------------------
module shash_sched (
   input  logic                      clock,
   input  shash_pkg::sched_ctrl_type ctrl,
   output logic [31:0]               w_word
);

   // Word 0 of the window sits in the top 32 bits.
   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   logic [31:0]  w1;
   logic [31:0]  w9;
   logic [31:0]  w14;
   logic [31:0]  sig0;
   logic [31:0]  sig1;
   logic [31:0]  new_word;

   assign w_word = blk_ff[511:480];
   assign w1     = blk_ff[479:448];
   assign w9     = blk_ff[223:192];
   assign w14    = blk_ff[63:32];

   // Small sigma functions of the schedule recurrence.
   assign sig0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
   assign sig1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^
                 {10'b0, w14[31:10]};
   assign new_word = sig1 + w9 + sig0 + w_word;

   // Bytes shift in at the bottom; rounds shift a word out at the top.
   always_comb begin
      priority if (ctrl.load) begin
         blk_in = {blk_ff[503:0], ctrl.data};
      end else if (ctrl.step) begin
         blk_in = {blk_ff[479:0], new_word};
      end else begin
         blk_in = blk_ff;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

/* rtl/shash_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round, shared by all 64 rounds of every block.
// ----------------------------------------------------------------------------
module shash_round (
   input  shash_pkg::work_type cur,
   input  logic [31:0]         k_word,
   input  logic [31:0]         w_word,
   output shash_pkg::work_type nxt
);

   logic [31:0] big_s0;
   logic [31:0] big_s1;
   logic [31:0] choose;
   logic [31:0] majority;
   logic [31:0] t1;
   logic [31:0] t2;

   // Big sigma, choose and majority of the current working set.
   assign big_s1 = {cur.e[5:0], cur.e[31:6]} ^ {cur.e[10:0], cur.e[31:11]} ^
                   {cur.e[24:0], cur.e[31:25]};
   assign big_s0 = {cur.a[1:0], cur.a[31:2]} ^ {cur.a[12:0], cur.a[31:13]} ^
                   {cur.a[21:0], cur.a[31:22]};
   assign choose   = (cur.e & cur.f) ^ (~cur.e & cur.g);
   assign majority = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);

   assign t1 = cur.h + big_s1 + choose + k_word + w_word;
   assign t2 = big_s0 + majority;

   // Rotate the working set by one position.
   always_comb begin
      nxt.a = t1 + t2;
      nxt.b = cur.a;
      nxt.c = cur.b;
      nxt.d = cur.c;
      nxt.e = cur.d + t1;
      nxt.f = cur.e;
      nxt.g = cur.f;
      nxt.h = cur.g;
   end

endmodule

/* rtl/sha256_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Hashes a byte stream and returns the 256-bit digest as eight word beats.
// ----------------------------------------------------------------------------
// The core takes one message byte per beat while it is filling a block, one
// beat per cycle. The 64th byte of a block starts compression, which runs one
// round per cycle on a single shared round unit: the 64 rounds, then a fold
// of the result into the chaining value. The input is stalled while a block
// is compressed. At end of message the core shifts the pad byte, zero bytes
// and the 64-bit length into the block byte by byte, compresses the last one
// or two blocks, and then presents the eight digest words, word 0 first, one
// beat each. The input stays stalled until the last word is taken.

`include "sha256_stream_hasher_core_defines.svh"

module sha256_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_ZERO,
      ST_LENGTH,
      ST_OUTPUT
   } state_type;

   // Where the sequencer goes once a compression has been folded in.
   typedef enum logic [1:0] {
      RES_IDLE,
      RES_PAD,
      RES_ZERO,
      RES_OUTPUT
   } resume_type;

   state_type               state_ff;
   state_type               state_in;
   resume_type              resume_ff;
   resume_type              resume_in;
   logic [5:0]              fc_ff;
   logic [5:0]              fc_in;
   logic [63:0]             bits_ff;
   logic [63:0]             bits_in;
   logic [5:0]              rnd_ff;
   logic [5:0]              rnd_in;
   logic [2:0]              widx_ff;
   logic [2:0]              widx_in;
   logic [31:0]             chain_ff [8];
   logic [31:0]             chain_in [8];
   shash_pkg::work_type     work_ff;
   shash_pkg::work_type     work_in;
   shash_pkg::work_type     round_nxt;
   shash_pkg::sched_ctrl_type sched_ctrl;
   logic [31:0]             w_word;
   logic [63:0]             len_shift;
   logic                    start_comp;
   logic                    mid_out;
   logic                    last_out;
   logic                    full_in;
   logic                    msg_clear;

   // Message schedule window and the shared round unit.
   shash_sched u_sched (
      .clock  (clock),
      .ctrl   (sched_ctrl),
      .w_word (w_word)
   );

   shash_round u_round (
      .cur    (work_ff),
      .k_word (shash_pkg::ROUND_K[rnd_ff]),
      .w_word (w_word),
      .nxt    (round_nxt)
   );

   // Length bytes go out most significant first while the fill count runs
   // from 56 to 63.
   assign len_shift = bits_ff >> {~fc_ff[2:0], 3'b000};

   // Handshake and digest outputs.
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUTPUT);
   assign rsp_digest_word = chain_ff[widx_ff];
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == shash_pkg::LAST_WORD);

   // Sequencer next-state logic.
   always_comb begin
      state_in   = state_ff;
      resume_in  = resume_ff;
      fc_in      = fc_ff;
      bits_in    = bits_ff;
      rnd_in     = rnd_ff;
      widx_in    = widx_ff;
      work_in    = work_ff;
      chain_in   = chain_ff;
      sched_ctrl = '{load: 1'b0, step: 1'b0, data: 8'h00};
      start_comp = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_valid) begin
                  sched_ctrl.load = 1'b1;
                  sched_ctrl.data = req_data_byte;
                  fc_in           = fc_ff + 6'd1;
                  bits_in         = bits_ff + shash_pkg::BITS_PER_BYTE;
                  if (fc_ff == shash_pkg::LAST_POS) begin
                     start_comp = 1'b1;
                     resume_in  = req_end_of_message ? RES_PAD : RES_IDLE;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctrl.load = 1'b1;
            sched_ctrl.data = shash_pkg::PAD_BYTE;
            fc_in           = fc_ff + 6'd1;
            if (fc_ff == shash_pkg::LAST_POS) begin
               start_comp = 1'b1;
               resume_in  = RES_ZERO;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (fc_ff == shash_pkg::LENGTH_POS) begin
               state_in = ST_LENGTH;
            end else begin
               sched_ctrl.load = 1'b1;
               fc_in           = fc_ff + 6'd1;
               if (fc_ff == shash_pkg::LAST_POS) begin
                  start_comp = 1'b1;
                  resume_in  = RES_ZERO;
               end
            end
         end
         ST_LENGTH: begin
            sched_ctrl.load = 1'b1;
            sched_ctrl.data = len_shift[7:0];
            fc_in           = fc_ff + 6'd1;
            if (fc_ff == shash_pkg::LAST_POS) begin
               start_comp = 1'b1;
               resume_in  = RES_OUTPUT;
            end
         end
         ST_ROUND: begin
            work_in         = round_nxt;
            sched_ctrl.step = 1'b1;
            rnd_in          = rnd_ff + 6'd1;
            if (rnd_ff == shash_pkg::LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            chain_in[5] = chain_ff[5] + work_ff.f;
            chain_in[6] = chain_ff[6] + work_ff.g;
            chain_in[7] = chain_ff[7] + work_ff.h;
            widx_in     = 3'd0;
            unique case (resume_ff)
               RES_IDLE:   state_in = ST_IDLE;
               RES_PAD:    state_in = ST_PAD;
               RES_ZERO:   state_in = ST_ZERO;
               RES_OUTPUT: state_in = ST_OUTPUT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == shash_pkg::LAST_WORD) begin
                  chain_in = shash_pkg::INIT_HASH;
                  fc_in    = 6'd0;
                  bits_in  = 64'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the working set from the chaining value for a new block.
      if (start_comp) begin
         state_in = ST_ROUND;
         rnd_in   = 6'd0;
         work_in  = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2],
                      d: chain_ff[3], e: chain_ff[4], f: chain_ff[5],
                      g: chain_ff[6], h: chain_ff[7]};
      end
   end

   // Sequencer state, counters and chaining value.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= RES_IDLE;
         fc_ff     <= 6'd0;
         bits_ff   <= 64'd0;
         rnd_ff    <= 6'd0;
         widx_ff   <= 3'd0;
         chain_ff  <= shash_pkg::INIT_HASH;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         fc_ff     <= fc_in;
         bits_ff   <= bits_in;
         rnd_ff    <= rnd_in;
         widx_ff   <= widx_in;
         chain_ff  <= chain_in;
      end
   end

   // Round working set.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // Beat conditions watched by the checks below.
   assign mid_out   = rsp_valid && !rsp_stall && !rsp_last_word;
   assign last_out  = rsp_valid && !rsp_stall && rsp_last_word;
   assign full_in   = req_valid && !req_stall && req_byte_valid &&
                      (fc_ff == shash_pkg::LAST_POS);
   assign msg_clear = (state_ff == ST_IDLE) && (fc_ff == 6'd0) && (bits_ff == 64'd0);

   // Checks on the sequencer.
   `SHS_ASSERT_NOW(a_out_blocks_in, clock, reset, rsp_valid, req_stall, "input not stalled")
   `SHS_ASSERT_NEXT(a_burst_holds, clock, reset, mid_out, rsp_valid, "digest burst broken")
   `SHS_ASSERT_NEXT(a_full_block, clock, reset, full_in, state_ff == ST_ROUND, "no compression")
   `SHS_ASSERT_NEXT(a_digest_clears, clock, reset, last_out, msg_clear, "state not cleared")

endmodule

/* sim/sha256_stream_hasher_core_tb.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core testbench
// Feeds byte messages of many lengths with random idle and stall bursts, and
// checks every digest word against a built-in SHA-256 predictor.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_tb;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int unsigned LENGTH_FIELD = 56;
   localparam int unsigned RANDOM_ITEMS = 160;
   localparam int unsigned CALM_AFTER = 140;

   // Message lengths around the padding and block boundaries.
   localparam int unsigned EDGE_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   // Running SHA-256 state of the message in flight and the digest words owed.
   class digest_scoreboard;
      logic [31:0]     chain [8];
      logic [7:0]      blk [64];
      int unsigned     fill;
      logic [63:0]     nbits;
      digest_beat_type pending_words [$];
      int unsigned     failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) begin
            chain[i] = HASH_IV[i];
         end
         fill = 0;
         nbits = '0;
      endfunction

      function logic [31:0] ror(logic [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // Run the 64 rounds over the held block and fold into the chain.
      function void fold_block();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, g, h;
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
               s0 = ror(w[(t - 15) % 16], 7) ^ ror(w[(t - 15) % 16], 18) ^
                    (w[(t - 15) % 16] >> 3);
               s1 = ror(w[(t - 2) % 16], 17) ^ ror(w[(t - 2) % 16], 19) ^
                    (w[(t - 2) % 16] >> 10);
               w[t % 16] = s1 + w[(t - 7) % 16] + s0 + w[t % 16];
            end
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
                 ROUND_CONST[t] + w[t % 16];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // Take one accepted input beat; an end of message queues eight words.
      function void absorb_beat(logic [7:0] data, logic has_byte, logic ends);
         int unsigned pos;
         digest_beat_type beat;
         if (has_byte) begin
            blk[fill] = data;
            fill++;
            nbits += 64'd8;
            if (fill == 64) begin
               fold_block();
               fill = 0;
            end
         end
         if (!ends) begin
            return;
         end
         pos = fill;
         blk[pos] = PAD_MARK;
         pos++;
         // No room for the length field: zero out and spill into a second block.
         if (pos > LENGTH_FIELD) begin
            while (pos < 64) begin
               blk[pos] = 8'h00;
               pos++;
            end
            fold_block();
            pos = 0;
         end
         while (pos < LENGTH_FIELD) begin
            blk[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            blk[LENGTH_FIELD + i] = nbits[63 - 8 * i -: 8];
         end
         fold_block();
         for (int i = 0; i < 8; i++) begin
            beat.word = chain[i];
            beat.index = 3'(i);
            beat.last = (i == 7);
            pending_words = {pending_words, beat};
         end
         restart();
      endfunction

      // Compare one accepted digest beat with the oldest word owed.
      function void check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_beat_type want;
         if (pending_words.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Unexpected digest beat: word %h index %0d last %0b",
                        word, index, last);
            end
            return;
         end
         want = pending_words.pop_front();
         if (word !== want.word || index !== want.index || last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("Digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                        want.word, want.index, want.last, word, index, last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   logic        quiet = 1'b0;
   int unsigned items = 0;
   int unsigned stall_left = 0;

   digest_scoreboard sb = new();

   sha256_stream_hasher_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #2 clock = ~clock;

   // Check each accepted digest beat, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_word(rsp_digest_word, rsp_word_index, rsp_last_word);
      end
      if (quiet || reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one beat, optionally after an idle burst, and wait until taken.
   task automatic send_beat(input logic [7:0] data, input logic has_byte,
                            input logic ends);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_valid <= has_byte;
      req_end_of_message <= ends;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.absorb_beat(data, has_byte, ends);
      items++;
   endtask

   // Hold off the input until every owed digest word has come out.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_words.size() != 0);
   endtask

   // Random message content; the end either rides on the last byte or follows alone.
   task automatic send_message(input int unsigned len);
      logic joined;
      joined = ($urandom_range(0, 1) == 1) && (len != 0);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(8'($urandom), 1'b0, 1'b0);
         end
         send_beat(8'($urandom), 1'b1, joined && (i == len - 1));
      end
      if (!joined) begin
         send_beat(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   initial begin
      int unsigned len;
      logic short_first;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // End with no byte at all gives the empty-message digest.
      send_beat(8'($urandom), 1'b0, 1'b1);
      // Beats with neither byte nor end are ignored whatever the data.
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      // Three-byte message with the end on the last byte.
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      // Single zero byte, end on a beat of its own carrying ignored data.
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      // Single all-ones byte together with the end.
      send_beat(8'hff, 1'b1, 1'b1);
      // Back-to-back ends check the return to the initial hash.
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h80, 1'b0, 1'b1);
      hold_until_drained();

      // The lengths that just fit and just miss a single padded block.
      short_first = $urandom_range(0, 1);
      send_message(short_first ? 55 : 56);
      send_message(short_first ? 56 : 55);

      while (items < RANDOM_ITEMS) begin
         if (!quiet && items >= CALM_AFTER) begin
            quiet <= 1'b1;
         end
         if ($urandom_range(0, 4) == 0) begin
            len = EDGE_LENGTHS[$urandom_range(0, 7)];
         end else begin
            len = $urandom_range(0, 16);
         end
         // Keep the total close to the planned number of beats.
         if (len > RANDOM_ITEMS - items) begin
            len = RANDOM_ITEMS - items;
         end
         send_message(len);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            hold_until_drained();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #1600000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
